@@ src/btc_pkg.sv @@
package btc_pkg;

   // Fixed field widths.
   localparam int BYTE_W  = 8;
   localparam int SIZE_W  = 5;
   localparam int PERM_W  = 64;
   localparam int ENTRY_W = 4;
   localparam int INDEX_W = 32;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] REG_BLOCK_SIZE = 32'd0;
   localparam logic [INDEX_W-1:0] REG_PERM_TABLE = 32'd1;
   localparam logic [INDEX_W-1:0] REG_MODE       = 32'd2;
   localparam logic [INDEX_W-1:0] REG_PAD_BYTE   = 32'd3;

   // Mode codes.
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // Register values after reset (permutation 1,2,0).
   localparam logic [SIZE_W-1:0] RESET_BLOCK_SIZE = 5'd3;
   localparam logic [PERM_W-1:0] RESET_PERM_TABLE = 64'h21;
   localparam logic [BYTE_W-1:0] RESET_PAD_BYTE   = 8'h00;

   // Configuration register set.
   typedef struct packed {
      logic [SIZE_W-1:0] block_size;
      logic [PERM_W-1:0] perm_table;
      logic              mode;
      logic [BYTE_W-1:0] pad_byte;
   } btc_cfg_type;

   // One queued block job: which bank, how many bytes were filled, message
   // end, and whether it is a lone length error word.
   typedef struct packed {
      logic              bank;
      logic [SIZE_W-1:0] count;
      logic              last;
      logic              err;
   } btc_job_type;

   // Bank release from the emitter back to the collector.
   typedef struct packed {
      logic valid;
      logic bank;
   } btc_release_type;

endpackage

@@ src/btc_queue.sv @@
module btc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  btc_pkg::btc_job_type push_job,
   input  logic                 pop,
   output btc_pkg::btc_job_type head_job,
   output logic                 full,
   output logic                 empty
);

   // Two-entry job queue between the collector and the emitter.
   btc_pkg::btc_job_type job_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           level_ff, level_in;

   assign full     = (level_ff == 2'd2);
   assign empty    = (level_ff == 2'd0);
   assign head_job = job_ff[rd_ptr_ff];

   // Pointer and level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (pop && !push) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/btc_front.sv @@
module btc_front #(
   parameter int MAX_BLOCK = 16,
   parameter int CNT_W     = $clog2(MAX_BLOCK + 1)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [btc_pkg::BYTE_W-1:0]                 req_tdata,
   input  logic                                       req_tlast,
   input  logic [CNT_W-1:0]                           bs_eff,
   input  logic                                       mode,
   input  logic                                       q_full,
   output logic                                       push,
   output btc_pkg::btc_job_type                       push_job,
   input  btc_pkg::btc_release_type                   rel,
   output logic [1:0][MAX_BLOCK-1:0][btc_pkg::BYTE_W-1:0] bank_data
);

   localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

   logic [btc_pkg::BYTE_W-1:0] bank_mem_ff [2][MAX_BLOCK];
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic                       bank_ff, bank_in;
   logic [1:0]                 busy_ff, busy_in;
   logic [CNT_W-1:0]           count_w;
   logic                       accept;

   // A word is taken only into a free bank and with room for its job.
   assign req_tready = !busy_ff[bank_ff] && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign count_w    = fill_ff + CNT_W'(1);

   // Classify each word: keep filling, close a full block, pad a short
   // final block, or flag a short final block when decrypting.
   always_comb begin
      fill_in  = fill_ff;
      bank_in  = bank_ff;
      push     = 1'b0;
      push_job = '{bank: bank_ff, count: btc_pkg::SIZE_W'(count_w),
                   last: req_tlast, err: 1'b0};
      if (accept) begin
         if (count_w >= bs_eff) begin
            push    = 1'b1;
            fill_in = '0;
            bank_in = ~bank_ff;
         end else if (req_tlast) begin
            push    = 1'b1;
            fill_in = '0;
            if (mode == btc_pkg::MODE_DECRYPT) begin
               push_job.err = 1'b1;
            end else begin
               bank_in = ~bank_ff;
            end
         end else begin
            fill_in = count_w;
         end
      end
   end

   // Bank ownership: set when a block job is queued, cleared by the emitter.
   always_comb begin
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (push && !push_job.err) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

   // Byte storage for both banks.
   always_ff @(posedge clock) begin
      if (accept) begin
         bank_mem_ff[bank_ff][fill_ff[IDX_W-1:0]] <= req_tdata;
      end
   end

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int p = 0; p < MAX_BLOCK; p++) begin
            bank_data[b][p] = bank_mem_ff[b][p];
         end
      end
   end

endmodule

@@ src/btc_back.sv @@
module btc_back #(
   parameter int MAX_BLOCK = 16,
   parameter int CNT_W     = $clog2(MAX_BLOCK + 1)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  btc_pkg::btc_job_type                       head_job,
   input  logic                                       q_empty,
   output logic                                       pop,
   output btc_pkg::btc_release_type                   rel,
   input  logic [CNT_W-1:0]                           bs_eff,
   input  btc_pkg::btc_cfg_type                       cfg,
   input  logic [1:0][MAX_BLOCK-1:0][btc_pkg::BYTE_W-1:0] bank_data,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [btc_pkg::BYTE_W-1:0]                 rsp_tdata,
   output logic                                       rsp_tlast,
   output logic [1:0]                                 rsp_tuser
);

   localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

   logic [IDX_W-1:0]             k_ff, k_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [btc_pkg::BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [1:0]                   rsp_user_ff, rsp_user_in;
   logic                         advance;
   logic                         blast;
   logic [btc_pkg::ENTRY_W-1:0]  src;
   logic [btc_pkg::SIZE_W-1:0]   bs5;
   logic [btc_pkg::BYTE_W-1:0]   enc_byte;
   logic [btc_pkg::BYTE_W-1:0]   dec_byte;
   logic                         found;
   logic [IDX_W-1:0]             sel_j;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign advance = !q_empty && (!rsp_valid_ff || rsp_tready);
   assign bs5     = btc_pkg::SIZE_W'(bs_eff);
   assign blast   = (CNT_W'(k_ff) == (bs_eff - CNT_W'(1)));

   // Encrypt: output k gathers from position perm[k]; positions past the
   // filled count are pad, entries beyond the block give zero.
   always_comb begin
      src      = cfg.perm_table[k_ff * btc_pkg::ENTRY_W +: btc_pkg::ENTRY_W];
      enc_byte = '0;
      if (btc_pkg::SIZE_W'(src) < bs5) begin
         if (btc_pkg::SIZE_W'(src) < head_job.count) begin
            enc_byte = bank_data[head_job.bank][src[IDX_W-1:0]];
         end else begin
            enc_byte = cfg.pad_byte;
         end
      end
   end

   // Decrypt: output k takes the lowest position j whose entry equals k.
   always_comb begin
      found = 1'b0;
      sel_j = '0;
      for (int j = MAX_BLOCK - 1; j >= 0; j--) begin
         if ((btc_pkg::SIZE_W'(j) < bs5) &&
             (cfg.perm_table[j * btc_pkg::ENTRY_W +: btc_pkg::ENTRY_W] ==
              btc_pkg::ENTRY_W'(k_ff))) begin
            found = 1'b1;
            sel_j = IDX_W'(j);
         end
      end
      dec_byte = found ? bank_data[head_job.bank][sel_j] : '0;
   end

   // Emit one word per cycle from the job at the head of the queue, while the output is not stalled.
   always_comb begin
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      pop          = 1'b0;
      rel          = '{valid: 1'b0, bank: head_job.bank};
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (head_job.err) begin
            rsp_data_in = '0;
            rsp_last_in = 1'b0;
            rsp_user_in = 2'b11;
            pop         = 1'b1;
         end else begin
            rsp_data_in = (cfg.mode == btc_pkg::MODE_DECRYPT) ? dec_byte : enc_byte;
            rsp_last_in = blast;
            rsp_user_in = {1'b0, blast && head_job.last};
            if (blast) begin
               k_in      = '0;
               pop       = 1'b1;
               rel.valid = 1'b1;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

@@ src/block_transposition_cipher_core.sv @@
// A block's job is queued when the word that completes the block (or ends the
// message) is accepted; the emitter then reads it from the queue head into the output register.
// Throughput: one word per cycle in and out while neither side stalls; two byte
// banks let the next block fill while the emitter reads the previous one.
// Reset: clears the fill count, bank ownership, the job queue, the output valid
// flag and the configuration registers; the byte banks are not cleared.
module block_transposition_cipher_core #(
   parameter int MAX_BLOCK = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input words.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [btc_pkg::BYTE_W-1:0]          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // msg_last
   // Result words.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [btc_pkg::BYTE_W-1:0]          rsp_tdata,   // [7:0] out_byte
   output logic                                rsp_tlast,   // block_last
   output logic [1:0]                          rsp_tuser,   // [0] msg_end, [1] length_error
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [btc_pkg::INDEX_W-1:0]         csr_index,
   input  logic [btc_pkg::PERM_W-1:0]          csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   btc_pkg::btc_cfg_type     cfg_ff, cfg_in;
   logic [CNT_W-1:0]         bs_eff;
   logic                     q_push, q_pop, q_full, q_empty;
   btc_pkg::btc_job_type     push_job, head_job;
   btc_pkg::btc_release_type rel;
   logic [1:0][MAX_BLOCK-1:0][btc_pkg::BYTE_W-1:0] bank_data;

   assign csr_ready = 1'b1;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            btc_pkg::REG_BLOCK_SIZE: cfg_in.block_size = csr_wdata[btc_pkg::SIZE_W-1:0];
            btc_pkg::REG_PERM_TABLE: cfg_in.perm_table = csr_wdata;
            btc_pkg::REG_MODE:       cfg_in.mode       = csr_wdata[0];
            btc_pkg::REG_PAD_BYTE:   cfg_in.pad_byte   = csr_wdata[btc_pkg::BYTE_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{block_size: btc_pkg::RESET_BLOCK_SIZE,
                     perm_table: btc_pkg::RESET_PERM_TABLE,
                     mode:       btc_pkg::MODE_ENCRYPT,
                     pad_byte:   btc_pkg::RESET_PAD_BYTE};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Effective block size: zero acts as one, large sizes saturate.
   always_comb begin
      if (cfg_ff.block_size == '0) begin
         bs_eff = CNT_W'(1);
      end else if (cfg_ff.block_size > btc_pkg::SIZE_W'(MAX_BLOCK)) begin
         bs_eff = CNT_W'(MAX_BLOCK);
      end else begin
         bs_eff = cfg_ff.block_size[CNT_W-1:0];
      end
   end

   btc_front #(.MAX_BLOCK(MAX_BLOCK), .CNT_W(CNT_W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .bs_eff     (bs_eff),
      .mode       (cfg_ff.mode),
      .q_full     (q_full),
      .push       (q_push),
      .push_job   (push_job),
      .rel        (rel),
      .bank_data  (bank_data)
   );

   btc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   btc_back #(.MAX_BLOCK(MAX_BLOCK), .CNT_W(CNT_W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_empty    (q_empty),
      .pop        (q_pop),
      .rel        (rel),
      .bs_eff     (bs_eff),
      .cfg        (cfg_ff),
      .bank_data  (bank_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The collector never queues a job into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("job pushed into a full queue");

   // The emitter only retires a job that is present.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("job popped from an empty queue");

   // A bank is released only when its block job retires.
   assert property (@(posedge clock) disable iff (reset) rel.valid |-> q_pop)
      else $error("bank released without retiring a job");

   // A length error word closes the message and is not part of a block.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tuser[0] && !rsp_tlast))
      else $error("length error word with wrong flags");

endmodule
